@@ src/gsd_pkg.sv @@
`default_nettype none

package gsd_pkg;

   localparam int GYRO_W      = 16;
   localparam int STEP_W      = 16;
   localparam int CHANGE_W    = 16;
   localparam int PERIOD_W    = 6;
   localparam int VOTE_W      = 6;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CHANGE_W-1:0] MIN_CHANGE_RESET  = 16'd500;
   localparam logic [CHANGE_W-1:0] MAX_CHANGE_RESET  = 16'd5000;
   localparam logic [PERIOD_W-1:0] VOTE_PERIOD_RESET = 6'd30;
   localparam logic [VOTE_W-1:0]   VOTE_MAX          = 6'd63;

   typedef enum logic [1:0] {
      AXIS_NONE = 2'd0,
      AXIS_X    = 2'd1,
      AXIS_Y    = 2'd2,
      AXIS_Z    = 2'd3
   } axis_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_MIN_CHANGE  = 2'd0,
      REG_MAX_CHANGE  = 2'd1,
      REG_VOTE_PERIOD = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [CHANGE_W-1:0] min_change;
      logic [CHANGE_W-1:0] max_change;
      logic [PERIOD_W-1:0] vote_period;
   } cfg_type;

   // strict maximum of three unsigned values, none on a tie
   function automatic axis_type strict_winner(input logic [CHANGE_W-1:0] a,
                                              input logic [CHANGE_W-1:0] b,
                                              input logic [CHANGE_W-1:0] c);
      axis_type w;
      if (a > b && a > c) begin
         w = AXIS_X;
      end else if (b > a && b > c) begin
         w = AXIS_Y;
      end else if (c > a && c > b) begin
         w = AXIS_Z;
      end else begin
         w = AXIS_NONE;
      end
      return w;
   endfunction

endpackage

`default_nettype wire

@@ src/gyro_step_detector_unit.sv @@
`default_nettype none

// Gyro step detector. Takes one three-axis gyro sample per cycle on the req_
// channel; every SAMPLES_PER_UPDATE samples it closes a batch and, via the
// queue and back pipeline registers, delivers one result on rsp_ (running
// step count, active axis, step flag); samples that do not close a batch give
// no result. The front sums the batch, a two-entry queue holds finished batch
// sums, and the back divides the sums by the batch size (reciprocal multiply,
// two stages), runs the per-axis update and voting, then the
// midpoint-crossing step test. The sustained rate is one sample per cycle;
// the back pipeline halts only while a result waits on rsp_ready, and then
// the queue lets the front keep taking samples until two batches are pending.
// Registers on csr_: 0 min_change, 1 max_change, 2 vote_period; other indexes
// are ignored. Write them only while the block is idle.
module gyro_step_detector_unit #(
   parameter int SAMPLES_PER_UPDATE = 10
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_wr_en,
   input  wire logic [gsd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [gsd_pkg::CSR_DATA_W-1:0]       csr_data,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic signed [gsd_pkg::GYRO_W-1:0]    req_gyro_x,
   input  wire logic signed [gsd_pkg::GYRO_W-1:0]    req_gyro_y,
   input  wire logic signed [gsd_pkg::GYRO_W-1:0]    req_gyro_z,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [gsd_pkg::STEP_W-1:0]                rsp_step_total,
   output logic [1:0]                                rsp_active_axis,
   output logic                                      rsp_step_seen
);
   import gsd_pkg::*;

   // batch sum is wider than one sample by the ceiling of log2 of the batch size
   localparam int SUM_W = GYRO_W + $clog2(SAMPLES_PER_UPDATE);
   localparam int Q_W   = 3 * SUM_W;

   cfg_type           cfg_ff;
   logic              push_valid;
   logic              push_ready;
   logic [Q_W-1:0]    push_data;
   logic              pop_valid;
   logic              pop_ready;
   logic [Q_W-1:0]    pop_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_change  <= MIN_CHANGE_RESET;
         cfg_ff.max_change  <= MAX_CHANGE_RESET;
         cfg_ff.vote_period <= VOTE_PERIOD_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_MIN_CHANGE:  cfg_ff.min_change  <= csr_data;
            REG_MAX_CHANGE:  cfg_ff.max_change  <= csr_data;
            REG_VOTE_PERIOD: cfg_ff.vote_period <= csr_data[PERIOD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // front: batch accumulation
   gsd_front #(
      .SAMPLES (SAMPLES_PER_UPDATE),
      .SUM_W   (SUM_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_gyro_x (req_gyro_x),
      .req_gyro_y (req_gyro_y),
      .req_gyro_z (req_gyro_z),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // finished batches waiting for the back
   gsd_queue #(
      .WIDTH (Q_W),
      .DEPTH (2)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // back: average, peaks, voting, step test, result register
   gsd_back #(
      .SAMPLES (SAMPLES_PER_UPDATE),
      .SUM_W   (SUM_W)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_data        (pop_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_step_total  (rsp_step_total),
      .rsp_active_axis (rsp_active_axis),
      .rsp_step_seen   (rsp_step_seen)
   );

endmodule

`default_nettype wire

@@ src/gsd_front.sv @@
`default_nettype none

module gsd_front #(
   parameter int SAMPLES = 10,
   parameter int SUM_W   = 20
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic signed [gsd_pkg::GYRO_W-1:0] req_gyro_x,
   input  wire logic signed [gsd_pkg::GYRO_W-1:0] req_gyro_y,
   input  wire logic signed [gsd_pkg::GYRO_W-1:0] req_gyro_z,
   output logic                                   push_valid,
   input  wire logic                              push_ready,
   output logic [3*SUM_W-1:0]                     push_data
);
   import gsd_pkg::*;

   localparam int FILL_W = $clog2(SAMPLES + 1);

   logic signed [SUM_W-1:0] sum_ff [3];
   logic signed [SUM_W-1:0] sum_in [3];
   logic [FILL_W-1:0]       fill_ff;
   logic                    batch_end;
   logic                    accept;

   assign batch_end = (fill_ff == FILL_W'(SAMPLES - 1));
   // only the batch-closing sample needs queue space
   assign req_ready = !batch_end || push_ready;
   assign accept    = req_valid && req_ready;

   assign sum_in[0] = sum_ff[0] + SUM_W'(req_gyro_x);
   assign sum_in[1] = sum_ff[1] + SUM_W'(req_gyro_y);
   assign sum_in[2] = sum_ff[2] + SUM_W'(req_gyro_z);

   assign push_valid = req_valid && batch_end;
   assign push_data  = {sum_in[2], sum_in[1], sum_in[0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         for (int i = 0; i < 3; i++) sum_ff[i] <= '0;
      end else if (accept) begin
         if (batch_end) begin
            fill_ff <= '0;
            for (int i = 0; i < 3; i++) sum_ff[i] <= '0;
         end else begin
            fill_ff <= fill_ff + 1'b1;
            for (int i = 0; i < 3; i++) sum_ff[i] <= sum_in[i];
         end
      end
   end

endmodule

`default_nettype wire

@@ src/gsd_queue.sv @@
`default_nettype none

module gsd_queue #(
   parameter int WIDTH = 60,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output logic [WIDTH-1:0]      pop_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

@@ src/gsd_div.sv @@
`default_nettype none

// Two-stage signed division by a constant, truncating toward zero.
// Stage 1: magnitude times reciprocal. Stage 2: one correction step.
module gsd_div #(
   parameter int SUM_W   = 20,
   parameter int DIVISOR = 10
) (
   input  wire logic                       clock,
   input  wire logic                       enable,
   input  wire logic signed [SUM_W-1:0]    sum,
   output logic signed [gsd_pkg::GYRO_W-1:0] avg
);
   import gsd_pkg::*;

   localparam int SH      = SUM_W;
   localparam int RECIP_W = SH + 1;
   localparam int PROD_W  = SUM_W + RECIP_W;
   localparam int DIV_W   = $clog2(DIVISOR + 1);
   localparam int QN_W    = SUM_W + DIV_W;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << SH) / DIVISOR);

   logic [SUM_W-1:0]  mag;
   logic [PROD_W-1:0] prod;
   logic [SUM_W-1:0]  mag_ff;
   logic              neg_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [SUM_W-1:0]  q_est;
   logic [QN_W-1:0]   q_back;
   logic [SUM_W-1:0]  rem;
   logic [SUM_W-1:0]  q_fix;
   logic [SUM_W-1:0]  q_signed;
   logic signed [GYRO_W-1:0] avg_ff;

   assign mag  = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
   assign prod = PROD_W'(mag) * PROD_W'(RECIP);

   // estimate is low by at most one
   assign q_est    = prod_ff[SH +: SUM_W];
   assign q_back   = QN_W'(q_est) * QN_W'(DIVISOR);
   assign rem      = mag_ff - q_back[SUM_W-1:0];
   assign q_fix    = (rem >= SUM_W'(DIVISOR)) ? q_est + 1'b1 : q_est;
   assign q_signed = neg_ff ? (~q_fix + 1'b1) : q_fix;

   always_ff @(posedge clock) begin
      if (enable) begin
         mag_ff  <= mag;
         neg_ff  <= sum[SUM_W-1];
         prod_ff <= prod;
         avg_ff  <= $signed(q_signed[GYRO_W-1:0]);
      end
   end

   assign avg = avg_ff;

endmodule

`default_nettype wire

@@ src/gsd_back.sv @@
`default_nettype none

module gsd_back #(
   parameter int SAMPLES = 10,
   parameter int SUM_W   = 20
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire gsd_pkg::cfg_type            cfg,
   input  wire logic                        pop_valid,
   output logic                             pop_ready,
   input  wire logic [3*SUM_W-1:0]          pop_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [gsd_pkg::STEP_W-1:0]       rsp_step_total,
   output logic [1:0]                       rsp_active_axis,
   output logic                             rsp_step_seen
);
   import gsd_pkg::*;

   // whole pipeline moves together; it halts only on a held result
   logic adv;
   logic upd_fire;

   logic d1_valid_ff;
   logic d2_valid_ff;
   logic s_valid_ff;

   logic signed [GYRO_W-1:0] avg [3];

   // per-axis update state
   logic signed [GYRO_W-1:0] cur_ff  [3];
   logic signed [GYRO_W-1:0] high_ff [3];
   logic signed [GYRO_W-1:0] low_ff  [3];
   logic [VOTE_W-1:0]        votes_ff [3];
   logic [PERIOD_W-1:0]      vcount_ff;
   axis_type                 chosen_ff;

   logic signed [GYRO_W-1:0] cur_in  [3];
   logic signed [GYRO_W-1:0] high_in [3];
   logic signed [GYRO_W-1:0] low_in  [3];
   logic [VOTE_W-1:0]        votes_in [3];
   logic [VOTE_W-1:0]        votes_base [3];
   logic [PERIOD_W-1:0]      vcount_in;
   logic [PERIOD_W-1:0]      vcount_inc;
   axis_type                 chosen_in;
   logic signed [GYRO_W:0]   diff [3];
   logic [GYRO_W:0]          diff_abs [3];
   logic [CHANGE_W-1:0]      gap_mag [3];
   logic                     reject [3];
   logic [CHANGE_W-1:0]      change [3];
   axis_type                 vote_axis;
   logic                     decide;

   // step test stage
   logic                     s_armed_ff;
   axis_type                 s_axis_ff;
   logic signed [GYRO_W-1:0] s_prev_ff;
   logic signed [GYRO_W-1:0] s_cur_ff;
   logic signed [GYRO_W-1:0] s_high_ff;
   logic signed [GYRO_W-1:0] s_low_ff;
   logic                     s_armed_in;
   logic signed [GYRO_W-1:0] s_prev_in;
   logic signed [GYRO_W-1:0] s_cur_in;
   logic signed [GYRO_W-1:0] s_high_in;
   logic signed [GYRO_W-1:0] s_low_in;

   logic signed [GYRO_W:0]   peak_sum;
   logic signed [GYRO_W:0]   peak_half;
   logic signed [GYRO_W:0]   mid;
   logic signed [GYRO_W:0]   p_ext;
   logic signed [GYRO_W:0]   c_ext;
   logic                     crossed;

   logic [STEP_W-1:0]        tally_ff;
   logic [STEP_W-1:0]        tally_in;

   logic                     rsp_valid_ff;
   logic [STEP_W-1:0]        rsp_total_ff;
   logic [1:0]               rsp_axis_ff;
   logic                     rsp_seen_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign pop_ready = adv;
   assign upd_fire  = d2_valid_ff && adv;

   for (genvar g = 0; g < 3; g++) begin : g_div
      gsd_div #(
         .SUM_W   (SUM_W),
         .DIVISOR (SAMPLES)
      ) u_div (
         .clock  (clock),
         .enable (adv),
         .sum    ($signed(pop_data[g*SUM_W +: SUM_W])),
         .avg    (avg[g])
      );
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff[i]     = (GYRO_W+1)'(avg[i]) - (GYRO_W+1)'(cur_ff[i]);
         diff_abs[i] = diff[i][GYRO_W] ? (GYRO_W+1)'(-diff[i]) : (GYRO_W+1)'(diff[i]);
         gap_mag[i]  = diff_abs[i][CHANGE_W-1:0];
         reject[i]   = (gap_mag[i] < cfg.min_change) || (gap_mag[i] > cfg.max_change);
         cur_in[i]   = reject[i] ? cur_ff[i] : avg[i];
         change[i]   = reject[i] ? '0 : gap_mag[i];
         high_in[i]  = (cur_in[i] > high_ff[i]) ? cur_in[i] : high_ff[i];
         low_in[i]   = (cur_in[i] < low_ff[i]) ? cur_in[i] : low_ff[i];
      end

      vcount_inc = vcount_ff + 1'b1;
      decide     = (vcount_inc >= cfg.vote_period);
      if (decide) begin
         chosen_in = strict_winner(CHANGE_W'(votes_ff[0]), CHANGE_W'(votes_ff[1]),
                                   CHANGE_W'(votes_ff[2]));
         vcount_in = '0;
         for (int i = 0; i < 3; i++) votes_base[i] = '0;
      end else begin
         chosen_in = chosen_ff;
         vcount_in = vcount_inc;
         for (int i = 0; i < 3; i++) votes_base[i] = votes_ff[i];
      end

      vote_axis = strict_winner(change[0], change[1], change[2]);
      for (int i = 0; i < 3; i++) votes_in[i] = votes_base[i];
      case (vote_axis)
         AXIS_X: begin
            if (votes_base[0] < VOTE_MAX) votes_in[0] = votes_base[0] + 1'b1;
         end
         AXIS_Y: begin
            if (votes_base[1] < VOTE_MAX) votes_in[1] = votes_base[1] + 1'b1;
         end
         AXIS_Z: begin
            if (votes_base[2] < VOTE_MAX) votes_in[2] = votes_base[2] + 1'b1;
         end
         default: begin
         end
      endcase

      // hand the chosen axis, as it stands after this update, to the step test
      s_armed_in = 1'b1;
      case (chosen_in)
         AXIS_X: begin
            s_prev_in = cur_ff[0];
            s_cur_in  = cur_in[0];
            s_high_in = high_in[0];
            s_low_in  = low_in[0];
         end
         AXIS_Y: begin
            s_prev_in = cur_ff[1];
            s_cur_in  = cur_in[1];
            s_high_in = high_in[1];
            s_low_in  = low_in[1];
         end
         AXIS_Z: begin
            s_prev_in = cur_ff[2];
            s_cur_in  = cur_in[2];
            s_high_in = high_in[2];
            s_low_in  = low_in[2];
         end
         default: begin
            s_armed_in = 1'b0;
            s_prev_in  = '0;
            s_cur_in   = '0;
            s_high_in  = '0;
            s_low_in   = '0;
         end
      endcase
   end

   // midpoint truncated toward zero
   assign peak_sum  = (GYRO_W+1)'(s_high_ff) + (GYRO_W+1)'(s_low_ff);
   assign peak_half = peak_sum + $signed({{GYRO_W{1'b0}}, peak_sum[GYRO_W]});
   assign mid       = peak_half >>> 1;
   assign p_ext     = (GYRO_W+1)'(s_prev_ff);
   assign c_ext     = (GYRO_W+1)'(s_cur_ff);
   assign crossed   = s_armed_ff && ((p_ext < mid && c_ext > mid) ||
                                     (p_ext > mid && c_ext < mid));
   assign tally_in  = tally_ff + STEP_W'(crossed);

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_valid_ff  <= 1'b0;
         d2_valid_ff  <= 1'b0;
         s_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         vcount_ff    <= '0;
         chosen_ff    <= AXIS_NONE;
         tally_ff     <= '0;
         for (int i = 0; i < 3; i++) begin
            cur_ff[i]   <= '0;
            high_ff[i]  <= '0;
            low_ff[i]   <= '0;
            votes_ff[i] <= '0;
         end
      end else if (adv) begin
         d1_valid_ff  <= pop_valid;
         d2_valid_ff  <= d1_valid_ff;
         s_valid_ff   <= d2_valid_ff;
         rsp_valid_ff <= s_valid_ff;
         if (d2_valid_ff) begin
            vcount_ff <= vcount_in;
            chosen_ff <= chosen_in;
            for (int i = 0; i < 3; i++) begin
               cur_ff[i]   <= cur_in[i];
               high_ff[i]  <= high_in[i];
               low_ff[i]   <= low_in[i];
               votes_ff[i] <= votes_in[i];
            end
         end
         if (s_valid_ff) begin
            tally_ff <= tally_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (upd_fire) begin
         s_armed_ff <= s_armed_in;
         s_axis_ff  <= chosen_in;
         s_prev_ff  <= s_prev_in;
         s_cur_ff   <= s_cur_in;
         s_high_ff  <= s_high_in;
         s_low_ff   <= s_low_in;
      end
      if (adv && s_valid_ff) begin
         rsp_total_ff <= tally_in;
         rsp_axis_ff  <= s_axis_ff;
         rsp_seen_ff  <= crossed;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_step_total  = rsp_total_ff;
   assign rsp_active_axis = rsp_axis_ff;
   assign rsp_step_seen   = rsp_seen_ff;

endmodule

`default_nettype wire

@@ src/gyro_step_detector_checker.sv @@
`default_nettype none

module gyro_step_detector_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_step_total,
   input wire logic [1:0]  rsp_active_axis,
   input wire logic        rsp_step_seen
);

   logic [15:0] last_total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_total_ff <= '0;
      end else if (rsp_valid && rsp_ready) begin
         last_total_ff <= rsp_step_total;
      end
   end

   // held result stays put until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_step_total) &&
      $stable(rsp_active_axis) && $stable(rsp_step_seen))
      else $error("result changed while stalled");

   // count advances by exactly the step flag between transfers
   a_tally: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |-> rsp_step_total == 16'(last_total_ff + 16'(rsp_step_seen)))
      else $error("step count out of line with step flag");

   // no step without an active axis
   a_step_axis: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_step_seen |-> rsp_active_axis != 2'd0)
      else $error("step counted with no active axis");

   // reset empties the result register
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind gyro_step_detector_unit gyro_step_detector_checker u_checker (.*);

`default_nettype wire
